>>> rtl/hvsp_frame_and_fuse_sequencer_defines.svh
// assertion macros for the hvsp sequencer checker
// expects signals named clock and reset in the using scope
`ifndef HVSP_FRAME_AND_FUSE_SEQUENCER_DEFINES_SVH
`define HVSP_FRAME_AND_FUSE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HVSP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hvsp check failed");

// next-cycle implication, disabled during reset
`define HVSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hvsp check failed");

`endif

>>> rtl/hvsp_pkg.sv
// shared types, codes and frame tables for the hvsp frame and fuse sequencer
// no dependencies
package hvsp_pkg;

   // command codes on the func field
   localparam logic [2:0] FUNC_TICK = 3'd0;
   localparam logic [2:0] FUNC_RAW  = 3'd1;
   localparam logic [2:0] FUNC_LOW  = 3'd2;
   localparam logic [2:0] FUNC_HIGH = 3'd3;
   localparam logic [2:0] FUNC_EXT  = 3'd4;

   // frame timing
   localparam logic [3:0] CLOCK_START      = 4'd0;
   localparam logic [3:0] CLOCK_FIRST_DATA = 4'd1;
   localparam logic [3:0] CLOCK_LAST_DATA  = 4'd8;
   localparam logic [3:0] CLOCK_LAST       = 4'd10;

   // fuse write frame numbers
   localparam logic [1:0] FRAME_ENABLE = 2'd0;
   localparam logic [1:0] FRAME_VALUE  = 2'd1;
   localparam logic [1:0] FRAME_TAIL_A = 2'd2;
   localparam logic [1:0] FRAME_LAST   = 2'd3;

   // fuse frame bytes
   localparam logic [7:0] ENABLE_DATA  = 8'h40;
   localparam logic [7:0] ENABLE_INSTR = 8'h4C;
   localparam logic [7:0] VALUE_INSTR  = 8'h2C;
   localparam logic [7:0] TAIL_DATA    = 8'h00;
   localparam logic [7:0] LOW_TAIL_A   = 8'h64;
   localparam logic [7:0] LOW_TAIL_B   = 8'h6C;
   localparam logic [7:0] HIGH_TAIL_A  = 8'h74;
   localparam logic [7:0] HIGH_TAIL_B  = 8'h7C;
   localparam logic [7:0] EXT_TAIL_A   = 8'h66;
   localparam logic [7:0] EXT_TAIL_B   = 8'h6E;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] data_byte;
      logic [7:0] instr_byte;
      logic       sdo_level;
   } req_type;

   typedef struct packed {
      logic       sdi_level;
      logic       sii_level;
      logic       clock_pulse;
      logic       busy_res;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       sequence_done;
   } rsp_type;

   typedef struct packed {
      logic       active;
      logic [2:0] command_kind;
      logic [1:0] frame_number;
      logic [3:0] clock_number;
      logic [7:0] data_shift;
      logic [7:0] instr_shift;
      logic [7:0] capture_shift;
      logic [7:0] fuse_value;
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] instr_byte;
   } frame_load_type;

   // bytes shifted out in one frame of a command
   function automatic frame_load_type frame_load(
      input logic [2:0] kind,
      input logic [1:0] frame,
      input logic [7:0] fuse,
      input logic [7:0] raw_data,
      input logic [7:0] raw_instr
   );
      frame_load_type ld;
      logic [7:0]     tail_a;
      logic [7:0]     tail_b;
      case (kind)
         FUNC_HIGH: begin
            tail_a = HIGH_TAIL_A;
            tail_b = HIGH_TAIL_B;
         end
         FUNC_EXT: begin
            tail_a = EXT_TAIL_A;
            tail_b = EXT_TAIL_B;
         end
         default: begin
            tail_a = LOW_TAIL_A;
            tail_b = LOW_TAIL_B;
         end
      endcase
      if (kind == FUNC_RAW) begin
         ld.data_byte  = raw_data;
         ld.instr_byte = raw_instr;
      end else begin
         case (frame)
            FRAME_ENABLE: begin
               ld.data_byte  = ENABLE_DATA;
               ld.instr_byte = ENABLE_INSTR;
            end
            FRAME_VALUE: begin
               ld.data_byte  = fuse;
               ld.instr_byte = VALUE_INSTR;
            end
            FRAME_TAIL_A: begin
               ld.data_byte  = TAIL_DATA;
               ld.instr_byte = tail_a;
            end
            default: begin
               ld.data_byte  = TAIL_DATA;
               ld.instr_byte = tail_b;
            end
         endcase
      end
      return ld;
   endfunction

endpackage

>>> rtl/hvsp_step.sv
// one serial clock tick of the sequencer: next state and result from state and item
// depends on hvsp_pkg
module hvsp_step (
   input  hvsp_pkg::state_type st,
   input  hvsp_pkg::req_type   item,
   output hvsp_pkg::state_type st_next,
   output hvsp_pkg::rsp_type   rsp
);
   import hvsp_pkg::*;

   state_type      s;
   frame_load_type ld;

   always_comb begin
      s   = st;
      rsp = '0;

      // start of a command while idle
      if (!s.active && (item.func inside {[FUNC_RAW:FUNC_EXT]})) begin
         s.active       = 1'b1;
         s.command_kind = item.func;
         s.fuse_value   = item.data_byte;
         s.frame_number = FRAME_ENABLE;
         s.clock_number = CLOCK_START;
      end

      ld = frame_load(s.command_kind, s.frame_number, s.fuse_value,
                      item.data_byte, item.instr_byte);

      if (s.active) begin
         rsp.clock_pulse = 1'b1;
         rsp.busy_res    = 1'b1;
         if (s.clock_number == CLOCK_START) begin
            s.data_shift    = ld.data_byte;
            s.instr_shift   = ld.instr_byte;
            s.capture_shift = '0;
            s.clock_number  = CLOCK_FIRST_DATA;
         end else if (s.clock_number <= CLOCK_LAST_DATA) begin
            rsp.sdi_level   = s.data_shift[7];
            rsp.sii_level   = s.instr_shift[7];
            s.data_shift    = {s.data_shift[6:0], 1'b0};
            s.instr_shift   = {s.instr_shift[6:0], 1'b0};
            s.capture_shift = {s.capture_shift[6:0], item.sdo_level};
            s.clock_number  = s.clock_number + 4'd1;
         end else if (s.clock_number < CLOCK_LAST) begin
            s.clock_number = s.clock_number + 4'd1;
         end else begin
            rsp.read_valid = 1'b1;
            rsp.read_byte  = s.capture_shift;
            s.clock_number = CLOCK_START;
            if (s.command_kind == FUNC_RAW || s.frame_number == FRAME_LAST) begin
               rsp.sequence_done = 1'b1;
               s.active          = 1'b0;
               s.frame_number    = FRAME_ENABLE;
            end else begin
               s.frame_number = s.frame_number + 2'd1;
            end
         end
      end

      st_next = s;
   end

endmodule

>>> rtl/hvsp_frame_and_fuse_sequencer.sv
// top level of the hvsp frame and fuse sequencer: input register, step logic, result register
// depends on hvsp_pkg and hvsp_step
//
// Master side of a high-voltage serial programming frame. Every item on the req
// channel is one serial clock tick and gives exactly one item on the rsp channel. While idle,
// func starts a raw frame (data_byte / instr_byte shifted out) or a four-frame fuse write
// (low, high or extended, data_byte is the fuse value); func is ignored while busy. A frame
// is a 0 start clock, eight data clocks MSB first on sdi/sii while sdo is captured MSB first,
// and two 0 clocks; read_byte and read_valid come on the last clock of each frame and
// sequence_done on the last clock of the command. Rate: one item per clock while rsp is not
// stalled. An accepted item lands in the input register, passes the combinational step logic,
// and its result is registered in the result register when that register can take it, ready
// to be taken from there when rsp is not stalled.
// The input register and the result register together hold two items, so req_stall rises
// only while a result waits under rsp_stall and the input register is occupied.
module hvsp_frame_and_fuse_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hvsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hvsp_pkg::rsp_type rsp_data
);
   import hvsp_pkg::*;

   // input register
   logic      in_valid_ff;
   req_type   in_data_ff;

   // result register
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;

   // command state, advanced once per tick that moves into the result register
   state_type state_ff;
   state_type state_in;

   logic      advance;

   // result register can take a new item when empty or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   hvsp_step u_step (
      .st      (state_ff),
      .item    (in_data_ff),
      .st_next (state_in),
      .rsp     (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // sequencer state only moves with a tick that completes the step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance && in_valid_ff) begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/hvsp_checker.sv
// port-level checks for the hvsp frame and fuse sequencer, bound to the top level
// depends on hvsp_pkg and hvsp_frame_and_fuse_sequencer_defines.svh
`include "hvsp_frame_and_fuse_sequencer_defines.svh"

module hvsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hvsp_pkg::rsp_type rsp_data
);
   import hvsp_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && !req_stall;

   // a stalled result holds
   `HVSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // an accepted item reaches the result register, raising rsp_valid, unless the result side stalls
   `HVSP_ASSERT_NEXT(a_latency, req_fire ##1 !rsp_stall, rsp_valid)

   // end of command is always the end of a frame on a clocked tick
   `HVSP_ASSERT_NOW(a_done_frame, rsp_valid && rsp_data.sequence_done,
                    rsp_data.read_valid && rsp_data.busy_res && rsp_data.clock_pulse)

   // no read byte outside a frame end
   `HVSP_ASSERT_NOW(a_read_gated, rsp_valid && !rsp_data.read_valid,
                    rsp_data.read_byte == 8'h00)

endmodule

bind hvsp_frame_and_fuse_sequencer hvsp_checker u_checker (.*);
